/* src/sas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types and codes of the segregation agent engine: request and
// response payloads, status codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
package sas_pkg;

  // default sizes handed to the top level
  localparam int MAX_GRID_W_DEF = 256;
  localparam int MAX_GRID_H_DEF = 256;
  localparam int MAX_AGENTS_DEF = 65536;
  localparam int MAX_TEAMS_DEF  = 5;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_W    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_H    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AGENT_CNT = 2'd3;

  // register reset values
  localparam logic [8:0]  GRID_W_RST    = 9'd256;
  localparam logic [8:0]  GRID_H_RST    = 9'd256;
  localparam logic [8:0]  RATE_RST      = 9'd192;
  localparam logic [16:0] AGENT_CNT_RST = 17'd0;

  // request kinds
  localparam logic REQ_PLACE = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // response status codes
  localparam logic [2:0] ST_PLACED = 3'd0;
  localparam logic [2:0] ST_STAYS  = 3'd1;
  localparam logic [2:0] ST_MOVED  = 3'd2;
  localparam logic [2:0] ST_RETRY  = 3'd3;
  localparam logic [2:0] ST_REJECT = 3'd4;

  // grid cell holding no agent
  localparam logic [2:0] CELL_EMPTY = 3'd7;

  typedef struct packed {
    logic        req_type;
    logic [15:0] agent_idx;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [2:0]  team;
  } sas_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] neighbour_count;
    logic [3:0] friend_count;
    logic [7:0] agent_x;
    logic [7:0] agent_y;
  } sas_rsp_t;

endpackage

/* src/sas_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_ram
// Single-port memory, one read or one write per cycle, registered read data.
// ----------------------------------------------------------------------------
module sas_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write or read, one port
  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/sas_nbr_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_nbr_unit
// Wrapped neighbour address unit: maps a neighbour index 0..7 and the agent
// position to the neighbour cell on the torus of the current size.
// ----------------------------------------------------------------------------
module sas_nbr_unit #(
  parameter int MAX_GRID_W = sas_pkg::MAX_GRID_W_DEF,
  parameter int MAX_GRID_H = sas_pkg::MAX_GRID_H_DEF,
  localparam int WB  = $clog2(MAX_GRID_W),
  localparam int HB  = $clog2(MAX_GRID_H),
  localparam int EWW = ($clog2(MAX_GRID_W + 1) > 9) ? $clog2(MAX_GRID_W + 1) : 9,
  localparam int EHW = ($clog2(MAX_GRID_H + 1) > 9) ? $clog2(MAX_GRID_H + 1) : 9
) (
  input  logic [2:0]     k_i,
  input  logic [WB-1:0]  ax_i,
  input  logic [HB-1:0]  ay_i,
  input  logic [EWW-1:0] w_i,
  input  logic [EHW-1:0] h_i,
  output logic [WB-1:0]  nx_o,
  output logic [HB-1:0]  ny_o
);

  localparam logic [1:0] OFF_M = 2'd0;
  localparam logic [1:0] OFF_Z = 2'd1;
  localparam logic [1:0] OFF_P = 2'd2;

  logic [1:0] dx, dy;

  // column step with wrap
  function automatic logic [WB-1:0] step_x(input logic [1:0] d, input logic [WB-1:0] a,
                                           input logic [EWW-1:0] w);
    logic [EWW-1:0] a_inc;
    logic [WB-1:0]  r;
    a_inc = EWW'(a) + EWW'(1);
    case (d)
      OFF_M:   r = (a == '0) ? WB'(w - EWW'(1)) : a - WB'(1);
      OFF_P:   r = (a_inc == w) ? '0 : WB'(a_inc);
      default: r = a;
    endcase
    return r;
  endfunction

  // row step with wrap
  function automatic logic [HB-1:0] step_y(input logic [1:0] d, input logic [HB-1:0] a,
                                           input logic [EHW-1:0] h);
    logic [EHW-1:0] a_inc;
    logic [HB-1:0]  r;
    a_inc = EHW'(a) + EHW'(1);
    case (d)
      OFF_M:   r = (a == '0) ? HB'(h - EHW'(1)) : a - HB'(1);
      OFF_P:   r = (a_inc == h) ? '0 : HB'(a_inc);
      default: r = a;
    endcase
    return r;
  endfunction

  // neighbour index to offsets, own cell skipped
  always_comb begin
    case (k_i)
      3'd0:    begin dx = OFF_M; dy = OFF_M; end
      3'd1:    begin dx = OFF_Z; dy = OFF_M; end
      3'd2:    begin dx = OFF_P; dy = OFF_M; end
      3'd3:    begin dx = OFF_M; dy = OFF_Z; end
      3'd4:    begin dx = OFF_P; dy = OFF_Z; end
      3'd5:    begin dx = OFF_M; dy = OFF_P; end
      3'd6:    begin dx = OFF_Z; dy = OFF_P; end
      default: begin dx = OFF_P; dy = OFF_P; end
    endcase
  end

  assign nx_o = step_x(dx, ax_i, w_i);
  assign ny_o = step_y(dy, ay_i, h_i);

endmodule

/* src/schelling_agent_step.sv */
`timescale 1ns / 1ps
// Flow: S_IDLE takes an item and reads its agent word; S_DEC rejects early or goes on
// to S_PCHK (place) or to S_NBR, S_NLAST, S_CMP and, if unhappy, S_CAND and on a move
// S_VAC (step); all end in S_DONE, which waits while the result is stalled. No new item
// is taken until S_IDLE. The single-port grid memory serialises a step: eight neighbour
// reads, a candidate read and the occupy and vacate writes share its one port. Reset:
// asynchronous, active low; then all grid and agent addresses are cleared, in_stall_o high.
// ----------------------------------------------------------------------------
// schelling_agent_step
// Segregation agent engine on a torus grid: places agents, counts wrapped
// neighbours and friends, and moves unhappy agents to a host-given candidate.
// ----------------------------------------------------------------------------
module schelling_agent_step #(
  parameter int MAX_GRID_W = sas_pkg::MAX_GRID_W_DEF,
  parameter int MAX_GRID_H = sas_pkg::MAX_GRID_H_DEF,
  parameter int MAX_AGENTS = sas_pkg::MAX_AGENTS_DEF,
  parameter int MAX_TEAMS  = sas_pkg::MAX_TEAMS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  sas_pkg::sas_req_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output sas_pkg::sas_rsp_t                out_data_o,
  input  logic                             cfg_we_i,
  input  logic [sas_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sas_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  import sas_pkg::*;

  localparam int WB  = $clog2(MAX_GRID_W);
  localparam int HB  = $clog2(MAX_GRID_H);
  localparam int GAW = WB + HB;
  localparam int AW  = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int AGW = WB + HB + 4;
  localparam int CW  = (GAW > AW) ? GAW : AW;
  localparam int EWW = ($clog2(MAX_GRID_W + 1) > 9) ? $clog2(MAX_GRID_W + 1) : 9;
  localparam int EHW = ($clog2(MAX_GRID_H + 1) > 9) ? $clog2(MAX_GRID_H + 1) : 9;

  localparam logic [EWW-1:0] MAX_W_C   = EWW'(MAX_GRID_W);
  localparam logic [EHW-1:0] MAX_H_C   = EHW'(MAX_GRID_H);
  localparam logic [24:0]    MAX_AG_C  = 25'(MAX_AGENTS);
  localparam logic [3:0]     MAX_TM_C  = 4'(MAX_TEAMS);

  // sequencer states
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_PCHK  = 4'd3;
  localparam logic [3:0] S_NBR   = 4'd4;
  localparam logic [3:0] S_NLAST = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_CAND  = 4'd7;
  localparam logic [3:0] S_VAC   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] clr_q, clr_d;
  logic [2:0]    k_q, k_d;
  logic [3:0]    nc_q, nc_d, fc_q, fc_d;
  logic          id_ok_q, id_ok_d;
  logic          out_valid_q, out_valid_d;
  sas_req_t      req_q, req_d;
  sas_rsp_t      res_q, res_d, out_q, out_d;
  logic [WB-1:0] ax_q, ax_d;
  logic [HB-1:0] ay_q, ay_d;
  logic [2:0]    grp_q, grp_d;

  logic [8:0]  grid_w_q, grid_h_q, rate_q;
  logic [16:0] agent_cnt_q;

  logic [EWW-1:0] w_eff;
  logic [EHW-1:0] h_eff;
  logic [8:0]     rate_eff;
  logic [24:0]    lim;

  // memory ports
  logic           g_en, g_we;
  logic [GAW-1:0] g_addr;
  logic [2:0]     g_wdata, g_rd;
  logic           a_en, a_we;
  logic [AW-1:0]  a_addr;
  logic [AGW-1:0] a_wdata, a_rd;

  logic          a_val;
  logic [WB-1:0] a_x, nx;
  logic [HB-1:0] a_y, ny;
  logic [2:0]    a_grp;
  logic [GAW-1:0] cand_addr;
  logic          px_in, py_in, team_ok, ax_in, ay_in, cand_ok, unhappy;
  logic          occ, same;
  logic [12:0]   prod, fc_sc;

  // effective configuration values
  always_comb begin
    if (grid_w_q == '0) begin
      w_eff = EWW'(1);
    end else if (EWW'(grid_w_q) > MAX_W_C) begin
      w_eff = MAX_W_C;
    end else begin
      w_eff = EWW'(grid_w_q);
    end
    if (grid_h_q == '0) begin
      h_eff = EHW'(1);
    end else if (EHW'(grid_h_q) > MAX_H_C) begin
      h_eff = MAX_H_C;
    end else begin
      h_eff = EHW'(grid_h_q);
    end
    rate_eff = (rate_q > 9'd256) ? 9'd256 : rate_q;
    lim      = (25'(agent_cnt_q) > MAX_AG_C) ? MAX_AG_C : 25'(agent_cnt_q);
  end

  // agent table word: valid, column, row, team
  assign a_val = a_rd[AGW-1];
  assign a_x   = a_rd[AGW-2 -: WB];
  assign a_y   = a_rd[HB+2 -: HB];
  assign a_grp = a_rd[2:0];

  // range checks and decisions
  assign px_in     = EWW'(req_q.pos_x) < w_eff;
  assign py_in     = EHW'(req_q.pos_y) < h_eff;
  assign team_ok   = {1'b0, req_q.team} < MAX_TM_C;
  assign ax_in     = EWW'(a_x) < w_eff;
  assign ay_in     = EHW'(a_y) < h_eff;
  assign cand_addr = {HB'(req_q.pos_y), WB'(req_q.pos_x)};
  assign cand_ok   = px_in && py_in && (g_rd == CELL_EMPTY);
  assign occ       = g_rd != CELL_EMPTY;
  assign same      = g_rd == grp_q;
  assign prod      = 13'(rate_eff) * 13'(nc_q);
  assign fc_sc     = {1'b0, fc_q, 8'd0};
  assign unhappy   = (nc_q != '0) && (fc_sc < prod);

  // wrapped neighbour address unit
  sas_nbr_unit #(
    .MAX_GRID_W (MAX_GRID_W),
    .MAX_GRID_H (MAX_GRID_H)
  ) u_nbr (
    .k_i  (k_q),
    .ax_i (ax_q),
    .ay_i (ay_q),
    .w_i  (w_eff),
    .h_i  (h_eff),
    .nx_o (nx),
    .ny_o (ny)
  );

  // occupancy grid
  sas_ram #(
    .WIDTH (3),
    .DEPTH (2 ** GAW)
  ) u_grid (
    .clk_i   (clk_i),
    .en_i    (g_en),
    .we_i    (g_we),
    .addr_i  (g_addr),
    .wdata_i (g_wdata),
    .rdata_o (g_rd)
  );

  // agent table
  sas_ram #(
    .WIDTH (AGW),
    .DEPTH (2 ** AW)
  ) u_agent (
    .clk_i   (clk_i),
    .en_i    (a_en),
    .we_i    (a_we),
    .addr_i  (a_addr),
    .wdata_i (a_wdata),
    .rdata_o (a_rd)
  );

  // memory port selection per state
  always_comb begin
    g_en    = 1'b0;
    g_we    = 1'b0;
    g_addr  = cand_addr;
    g_wdata = CELL_EMPTY;
    a_en    = 1'b0;
    a_we    = 1'b0;
    a_addr  = AW'(req_q.agent_idx);
    a_wdata = '0;
    case (state_q)
      S_CLR: begin
        g_en   = 1'b1;
        g_we   = 1'b1;
        g_addr = GAW'(clr_q);
        a_en   = 1'b1;
        a_we   = 1'b1;
        a_addr = AW'(clr_q);
      end
      S_IDLE: begin
        a_en   = in_valid_i;
        a_addr = AW'(in_data_i.agent_idx);
      end
      S_DEC: begin
        g_en = 1'b1;
      end
      S_PCHK: begin
        if (g_rd == CELL_EMPTY) begin
          g_en    = 1'b1;
          g_we    = 1'b1;
          g_wdata = req_q.team;
          a_en    = 1'b1;
          a_we    = 1'b1;
          a_wdata = {1'b1, WB'(req_q.pos_x), HB'(req_q.pos_y), req_q.team};
        end
      end
      S_NBR: begin
        g_en   = 1'b1;
        g_addr = {ny, nx};
      end
      S_CMP: begin
        g_en = 1'b1;
      end
      S_CAND: begin
        if (cand_ok) begin
          g_en    = 1'b1;
          g_we    = 1'b1;
          g_wdata = grp_q;
          a_en    = 1'b1;
          a_we    = 1'b1;
          a_wdata = {1'b1, WB'(req_q.pos_x), HB'(req_q.pos_y), grp_q};
        end
      end
      S_VAC: begin
        g_en    = 1'b1;
        g_we    = 1'b1;
        g_addr  = {ay_q, ax_q};
        g_wdata = CELL_EMPTY;
      end
      default: begin
        g_en = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    k_d         = k_q;
    nc_d        = nc_q;
    fc_d        = fc_q;
    id_ok_d     = id_ok_q;
    req_d       = req_q;
    res_d       = res_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    grp_d       = grp_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLR: begin
        clr_d = clr_q + CW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          id_ok_d = 25'(in_data_i.agent_idx) < lim;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        ax_d  = a_val ? a_x : '0;
        ay_d  = a_val ? a_y : '0;
        grp_d = a_grp;
        k_d   = '0;
        nc_d  = '0;
        fc_d  = '0;
        res_d.status          = ST_REJECT;
        res_d.neighbour_count = '0;
        res_d.friend_count    = '0;
        res_d.agent_x         = a_val ? 8'(a_x) : 8'd0;
        res_d.agent_y         = a_val ? 8'(a_y) : 8'd0;
        if (!id_ok_q) begin
          res_d.agent_x = 8'd0;
          res_d.agent_y = 8'd0;
          state_d       = S_DONE;
        end else if (req_q.req_type == REQ_PLACE) begin
          if (a_val || !px_in || !py_in || !team_ok) begin
            state_d = S_DONE;
          end else begin
            state_d = S_PCHK;
          end
        end else begin
          if (!a_val || !ax_in || !ay_in) begin
            state_d = S_DONE;
          end else begin
            state_d = S_NBR;
          end
        end
      end
      S_PCHK: begin
        if (g_rd == CELL_EMPTY) begin
          res_d.status  = ST_PLACED;
          res_d.agent_x = req_q.pos_x;
          res_d.agent_y = req_q.pos_y;
        end
        state_d = S_DONE;
      end
      S_NBR: begin
        // data of the previous neighbour is back now
        if (k_q != '0) begin
          nc_d = nc_q + 4'(occ);
          fc_d = fc_q + 4'(occ && same);
        end
        k_d = k_q + 3'd1;
        if (k_q == 3'd7) begin
          state_d = S_NLAST;
        end
      end
      S_NLAST: begin
        nc_d    = nc_q + 4'(occ);
        fc_d    = fc_q + 4'(occ && same);
        state_d = S_CMP;
      end
      S_CMP: begin
        res_d.status          = ST_STAYS;
        res_d.neighbour_count = nc_q;
        res_d.friend_count    = fc_q;
        res_d.agent_x         = 8'(ax_q);
        res_d.agent_y         = 8'(ay_q);
        state_d               = unhappy ? S_CAND : S_DONE;
      end
      S_CAND: begin
        if (cand_ok) begin
          res_d.status  = ST_MOVED;
          res_d.agent_x = req_q.pos_x;
          res_d.agent_y = req_q.pos_y;
          state_d       = S_VAC;
        end else begin
          res_d.status = ST_RETRY;
          state_d      = S_DONE;
        end
      end
      S_VAC: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      k_q         <= '0;
      nc_q        <= '0;
      fc_q        <= '0;
      id_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      k_q         <= k_d;
      nc_q        <= nc_d;
      fc_q        <= fc_d;
      id_ok_q     <= id_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    out_q <= out_d;
    ax_q  <= ax_d;
    ay_q  <= ay_d;
    grp_q <= grp_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q    <= GRID_W_RST;
      grid_h_q    <= GRID_H_RST;
      rate_q      <= RATE_RST;
      agent_cnt_q <= AGENT_CNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_W:    grid_w_q    <= cfg_wdata_i[8:0];
        REG_GRID_H:    grid_h_q    <= cfg_wdata_i[8:0];
        REG_RATE:      rate_q      <= cfg_wdata_i[8:0];
        REG_AGENT_CNT: agent_cnt_q <= cfg_wdata_i;
        default: begin
          rate_q <= rate_q;
        end
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/sas_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_checker
// Port-level checks of the segregation agent engine, bound to the top level.
// ----------------------------------------------------------------------------
module sas_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input sas_pkg::sas_req_t in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input sas_pkg::sas_rsp_t out_data_o
);

  import sas_pkg::*;

  // a stalled result stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  // one item at a time: busy right after a transfer in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  // place and reject carry no counts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_PLACED || out_data_o.status == ST_REJECT)
      |-> out_data_o.neighbour_count == 4'd0 && out_data_o.friend_count == 4'd0)
    else $error("counts on place or reject result");

  // friends are a subset of at most eight neighbours
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.friend_count <= out_data_o.neighbour_count &&
                    out_data_o.neighbour_count <= 4'd8)
    else $error("neighbour counts out of range");

endmodule

bind schelling_agent_step sas_checker u_sas_checker (.*);
